@@ rtl/etme_pkg.sv @@
// ============================================================================
// etme_pkg: shared types and constants for the edge table match engine
// Item layouts, segment storage format, opcodes and the bundles that pass
// between the sequencer and the match unit.
// ============================================================================
package etme_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int COORD_BITS    = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int DIFF_W        = COORD_BITS + 1;
  localparam int PROD_W        = 2 * DIFF_W;
  localparam int COUNT_BITS    = 7;
  // register stages in the match unit between probe and hit
  localparam int MATCH_LAT     = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_EQ  = 2'd1,
    OP_PAR = 2'd2,
    OP_REM = 2'd3
  } etme_op_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  typedef struct packed {
    logic [1:0] operation;
    coord_t     first_x;
    coord_t     first_y;
    coord_t     second_x;
    coord_t     second_y;
  } etme_in_t;

  typedef struct packed {
    logic                  found;
    logic                  overflow;
    logic [COUNT_BITS-1:0] entry_count;
  } etme_out_t;

  // stored segment
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } seg_t;

  // one table entry handed to the match unit
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } etme_probe_t;

  // verdict for one table entry
  typedef struct packed {
    logic             vld;
    logic             eq;
    logic             par;
    logic [IDX_W-1:0] idx;
  } etme_hit_t;

endpackage

@@ rtl/etme_match_unit.sv @@
// ============================================================================
// etme_match_unit: shared segment compare unit
// Takes one stored segment per cycle and tests it against the request for
// equality in either endpoint order and for parallel direction (exact cross
// product). Two register stages lie between the probe and the verdict.
// ============================================================================
module etme_match_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  etme_pkg::etme_probe_t probe,
  input  etme_pkg::seg_t       rd_seg,
  input  etme_pkg::seg_t       req,
  input  etme_pkg::diff_t      req_dx,
  input  etme_pkg::diff_t      req_dy,
  output etme_pkg::etme_hit_t  hit
);
  import etme_pkg::*;

  logic             vld_1_r, vld_2_r;
  logic [IDX_W-1:0] idx_1_r, idx_2_r;
  logic             eq_1_r,  eq_2_r;
  diff_t            sdx_1_r, sdy_1_r;
  prod_t            left_2_r, right_2_r;
  logic             same, swap;

  // endpoint compare, both orders
  assign same = (rd_seg.ax == req.ax) && (rd_seg.ay == req.ay) &&
                (rd_seg.bx == req.bx) && (rd_seg.by == req.by);
  assign swap = (rd_seg.bx == req.ax) && (rd_seg.by == req.ay) &&
                (rd_seg.ax == req.bx) && (rd_seg.ay == req.by);

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_1_r <= 1'b0;
      vld_2_r <= 1'b0;
    end else begin
      vld_1_r <= probe.vld;
      vld_2_r <= vld_1_r;
    end
  end

  // stage 1: equality and stored direction; stage 2: cross products
  always_ff @(posedge clk) begin
    idx_1_r   <= probe.idx;
    eq_1_r    <= same || swap;
    sdx_1_r   <= DIFF_W'(rd_seg.ax) - DIFF_W'(rd_seg.bx);
    sdy_1_r   <= DIFF_W'(rd_seg.ay) - DIFF_W'(rd_seg.by);
    idx_2_r   <= idx_1_r;
    eq_2_r    <= eq_1_r;
    left_2_r  <= PROD_W'(sdx_1_r) * PROD_W'(req_dy);
    right_2_r <= PROD_W'(sdy_1_r) * PROD_W'(req_dx);
  end

  assign hit.vld = vld_2_r;
  assign hit.eq  = eq_2_r;
  assign hit.par = (left_2_r == right_2_r);
  assign hit.idx = idx_2_r;

endmodule

@@ rtl/edge_table_match_engine.sv @@
// ============================================================================
// edge_table_match_engine: table of 2D segments with add, lookup and remove
// Sequencer walks the table one entry per cycle and feeds the shared match
// unit; it owns the segment memory, the slot valid bits and the entry count.
// ============================================================================
// Usage: raise start with a request while busy is low; busy then stays high
// until the result. An add walks the valid bits from slot 0 and stops at the
// lowest free slot, or after the last slot when the table is full. Lookups
// and removes read every entry through the single memory read port, one per
// cycle, and then wait for the two match-unit stages before the result.
// The result appears for one cycle with out_valid high and must be taken then;
// busy is already low in that cycle, so the next start may coincide with it.
module edge_table_match_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  etme_pkg::etme_in_t  in_item,
  output logic               out_valid,
  output etme_pkg::etme_out_t out_item
);
  import etme_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [1:0]       DRAIN_LAST = 2'(MATCH_LAT);

  state_t                  state_r;
  logic [1:0]              op_r;
  seg_t                    req_r;
  diff_t                   req_dx_r, req_dy_r;
  logic [IDX_W-1:0]        idx_r;
  logic [1:0]              drain_r;
  logic                    found_r, overflow_r;
  logic [TABLE_ENTRIES-1:0] slot_valid_r, valid_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    found_nxt;
  logic                    out_valid_r;
  etme_out_t               out_r;
  etme_probe_t             probe_r;
  seg_t                    rd_seg_r;
  seg_t                    mem [TABLE_ENTRIES];
  etme_hit_t               hit;
  logic                    add_free;
  seg_t                    in_seg;

  assign in_seg.ax = in_item.first_x;
  assign in_seg.ay = in_item.first_y;
  assign in_seg.bx = in_item.second_x;
  assign in_seg.by = in_item.second_y;

  assign add_free = (state_r == ST_SCAN) && (op_r == OP_ADD) && !slot_valid_r[idx_r];

  // shared compare unit
  etme_match_unit u_match (
    .clk    (clk),
    .rst_n  (rst_n),
    .probe  (probe_r),
    .rd_seg (rd_seg_r),
    .req    (req_r),
    .req_dx (req_dx_r),
    .req_dy (req_dy_r),
    .hit    (hit)
  );

  // segment memory: write on add, read at the scan index
  always_ff @(posedge clk) begin
    if (add_free) begin
      mem[idx_r] <= req_r;
    end
    rd_seg_r <= mem[idx_r];
  end

  // table bookkeeping from add and match verdicts
  always_comb begin
    valid_nxt = slot_valid_r;
    count_nxt = count_r;
    found_nxt = found_r;
    if (hit.vld && hit.eq && (op_r == OP_REM)) begin
      valid_nxt[hit.idx] = 1'b0;
      count_nxt          = count_r - CNT_W'(1);
      found_nxt          = 1'b1;
    end
    if (hit.vld && hit.eq && (op_r == OP_EQ)) begin
      found_nxt = 1'b1;
    end
    if (hit.vld && hit.par && (op_r == OP_PAR)) begin
      found_nxt = 1'b1;
    end
    if (add_free) begin
      valid_nxt[idx_r] = 1'b1;
      count_nxt        = count_r + CNT_W'(1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_valid_r <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      probe_r.vld  <= 1'b0;
    end else begin
      slot_valid_r <= valid_nxt;
      count_r      <= count_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= 1'b0;
      probe_r.vld  <= 1'b0;
      probe_r.idx  <= idx_r;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            op_r       <= in_item.operation;
            req_r      <= in_seg;
            req_dx_r   <= DIFF_W'(in_item.first_x) - DIFF_W'(in_item.second_x);
            req_dy_r   <= DIFF_W'(in_item.first_y) - DIFF_W'(in_item.second_y);
            found_r    <= (in_item.operation == OP_EQ) &&
                          (in_item.first_x == in_item.second_x) &&
                          (in_item.first_y == in_item.second_y);
            overflow_r <= 1'b0;
            idx_r      <= '0;
            state_r    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (op_r == OP_ADD) begin
            if (add_free || (idx_r == LAST_IDX)) begin
              out_valid_r          <= 1'b1;
              out_r.found          <= 1'b0;
              out_r.overflow       <= !add_free;
              out_r.entry_count    <= COUNT_BITS'(count_nxt);
              overflow_r           <= !add_free;
              state_r              <= ST_IDLE;
            end else begin
              idx_r <= idx_r + IDX_W'(1);
            end
          end else begin
            probe_r.vld <= slot_valid_r[idx_r];
            if (idx_r == LAST_IDX) begin
              drain_r <= '0;
              state_r <= ST_DRAIN;
            end else begin
              idx_r <= idx_r + IDX_W'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (drain_r == DRAIN_LAST) begin
            out_valid_r       <= 1'b1;
            out_r.found       <= found_nxt;
            out_r.overflow    <= overflow_r;
            out_r.entry_count <= COUNT_BITS'(count_nxt);
            state_r           <= ST_IDLE;
          end else begin
            drain_r <= drain_r + 2'd1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // checks
  a_count_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(slot_valid_r)))
    else $error("entry count disagrees with slot valid bits");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count above table size");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.overflow) |-> (count_r == CNT_W'(TABLE_ENTRIES)))
    else $error("add dropped with a free slot");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_no_hit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !hit.vld)
    else $error("match verdict while idle");

endmodule
